// ----- src/kdlq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kdlq_pkg
// Shared types and constants for the keypad debounce and event queue core.
// ----------------------------------------------------------------------------
package kdlq_pkg;

  localparam int KIND_W  = 2;
  localparam int KEY_W   = 4;
  localparam int LEVEL_W = 9;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 2;
  localparam int EVT_W   = 6;

  localparam logic [KIND_W-1:0] KIND_EDGE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_LONG     = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_LEVEL    = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [CFG_W-1:0] LONG_RST     = 16'd2000;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DEB   = 2'd1,
    PH_PRESS = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    EV_DOWN = 2'd0,
    EV_UP   = 2'd1,
    EV_LONG = 2'd2
  } ev_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_POP  = 2'd2
  } state_t;

  typedef struct packed {
    logic   enq;
    ev_t    ev;
    phase_t phase_nxt;
  } judge_t;

endpackage

`default_nettype wire

// ----- src/kdlq_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kdlq_ram
// Generic simple dual port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module kdlq_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                     wr_data,
  input  wire logic                                 rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- src/kdlq_ring.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kdlq_ring
// Event ring: pointers, full and empty detection around the ring memory.
// ----------------------------------------------------------------------------
module kdlq_ring #(
  parameter int QUEUE_SLOTS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire logic [kdlq_pkg::EVT_W-1:0]  push_data,
  input  wire logic                        pop,
  output logic      [kdlq_pkg::EVT_W-1:0]  pop_data,
  output logic                             empty
);

  localparam int PTR_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_SLOTS - 1);

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_inc, rd_inc;
  logic             full;
  logic             do_push, do_pop;

  assign wr_inc  = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
  assign rd_inc  = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
  assign full    = (wr_inc == rd_ptr_r);
  assign empty   = (wr_ptr_r == rd_ptr_r);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_inc : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_inc : rd_ptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  kdlq_ram #(
    .WIDTH (kdlq_pkg::EVT_W),
    .DEPTH (QUEUE_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (do_push),
    .wr_addr (wr_ptr_r),
    .wr_data (push_data),
    .rd_en   (do_pop),
    .rd_addr (rd_ptr_r),
    .rd_data (pop_data)
  );

endmodule

`default_nettype wire

// ----- src/kdlq_judge.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kdlq_judge
// Shared key judge: elapsed time subtract, compares and phase decision.
// ----------------------------------------------------------------------------
module kdlq_judge (
  input  wire kdlq_pkg::phase_t                phase,
  input  wire logic [kdlq_pkg::TIME_W-1:0]     start_time,
  input  wire logic [kdlq_pkg::TIME_W-1:0]     now_ms,
  input  wire logic                            act,
  input  wire logic [kdlq_pkg::CFG_W-1:0]      debounce_ms,
  input  wire logic [kdlq_pkg::CFG_W-1:0]      long_press_ms,
  output kdlq_pkg::judge_t                     res
);

  logic [kdlq_pkg::TIME_W-1:0] elapsed;
  logic                        deb_over;
  logic                        long_over;
  logic                        long_under;

  assign elapsed    = now_ms - start_time;
  assign deb_over   = elapsed > kdlq_pkg::TIME_W'(debounce_ms);
  assign long_over  = elapsed > kdlq_pkg::TIME_W'(long_press_ms);
  assign long_under = elapsed < kdlq_pkg::TIME_W'(long_press_ms);

  always_comb begin
    res.enq       = 1'b0;
    res.ev        = kdlq_pkg::EV_DOWN;
    res.phase_nxt = phase;
    case (phase)
      kdlq_pkg::PH_DEB: begin
        if (deb_over) begin
          if (act) begin
            res.enq       = 1'b1;
            res.ev        = kdlq_pkg::EV_DOWN;
            res.phase_nxt = kdlq_pkg::PH_PRESS;
          end else begin
            res.phase_nxt = kdlq_pkg::PH_IDLE;
          end
        end
      end
      kdlq_pkg::PH_PRESS: begin
        if (act) begin
          if (long_over) begin
            res.enq       = 1'b1;
            res.ev        = kdlq_pkg::EV_LONG;
            res.phase_nxt = kdlq_pkg::PH_IDLE;
          end
        end else begin
          res.enq       = long_under;
          res.ev        = kdlq_pkg::EV_UP;
          res.phase_nxt = kdlq_pkg::PH_IDLE;
        end
      end
      default: begin
        res.phase_nxt = phase;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/keypad_debounce_long_press_queue_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_debounce_long_press_queue_core
// Per-key debouncer with long press detection feeding an event ring.
// ----------------------------------------------------------------------------
// edge transaction: no busy state, next transaction accepted in the following cycle
// scan tick: one key a cycle through the shared judge
// read transaction: accept moves to S_POP, which loads the result register unless
// out_stall holds the previous result
// synchronous active-low reset: all keys idle, ring empty, control and config
// registers at their default values, no clearing pass
// ----------------------------------------------------------------------------
module keypad_debounce_long_press_queue_core #(
  parameter int NUM_KEYS    = 9,
  parameter int QUEUE_SLOTS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [kdlq_pkg::KIND_W-1:0]    in_kind,
  input  wire logic [kdlq_pkg::KEY_W-1:0]     in_key_index,
  input  wire logic [kdlq_pkg::LEVEL_W-1:0]   in_key_levels,
  input  wire logic [kdlq_pkg::TIME_W-1:0]    in_now_ms,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_event_valid,
  output logic      [1:0]                     out_event_type,
  output logic      [kdlq_pkg::KEY_W-1:0]     out_event_key,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [kdlq_pkg::CIDX_W-1:0]    cfg_index,
  input  wire logic [kdlq_pkg::CFG_W-1:0]     cfg_data
);

  localparam int KIDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [KIDX_W-1:0] KEY_LAST = KIDX_W'(NUM_KEYS - 1);

  kdlq_pkg::state_t state_r, state_nxt;
  kdlq_pkg::phase_t phase_r [NUM_KEYS];
  logic [kdlq_pkg::TIME_W-1:0] start_r [NUM_KEYS];

  logic [kdlq_pkg::CFG_W-1:0]  debounce_r;
  logic [kdlq_pkg::CFG_W-1:0]  long_r;
  logic                        level_r;

  logic [KIDX_W-1:0]           idx_r, idx_nxt;
  logic [kdlq_pkg::TIME_W-1:0] now_r;
  logic [kdlq_pkg::LEVEL_W-1:0] levels_r;
  logic [NUM_KEYS-1:0]         lvl_vec;
  logic                        hit_r, hit_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_ev_valid_r;
  logic [1:0]                  out_type_r;
  logic [kdlq_pkg::KEY_W-1:0]  out_key_r;
  logic                        out_load;

  logic                        in_acc;
  logic                        edge_acc;
  logic [KIDX_W-1:0]           edge_idx;
  logic                        edge_ok;
  logic                        scan_en;
  logic                        pop_req;
  logic                        ring_empty;
  logic [kdlq_pkg::EVT_W-1:0]  ring_q;
  logic [kdlq_pkg::EVT_W-1:0]  push_data;
  kdlq_pkg::judge_t            jres;

  assign in_stall  = (state_r != kdlq_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign edge_acc  = in_acc && (in_kind == kdlq_pkg::KIND_EDGE);
  assign edge_idx  = KIDX_W'(in_key_index);
  assign edge_ok   = (32'(in_key_index) < NUM_KEYS);
  assign pop_req   = in_acc && (in_kind == kdlq_pkg::KIND_READ);
  assign scan_en   = (state_r == kdlq_pkg::S_SCAN);
  assign out_load  = (state_r == kdlq_pkg::S_POP) && (!out_valid_r || !out_stall);

  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lvl
    if (g < kdlq_pkg::LEVEL_W) begin : g_in
      assign lvl_vec[g] = levels_r[g];
    end else begin : g_zero
      assign lvl_vec[g] = 1'b0;
    end
  end

  kdlq_judge u_judge (
    .phase         (phase_r[idx_r]),
    .start_time    (start_r[idx_r]),
    .now_ms        (now_r),
    .act           (lvl_vec[idx_r] == level_r),
    .debounce_ms   (debounce_r),
    .long_press_ms (long_r),
    .res           (jres)
  );

  assign push_data = {jres.ev, kdlq_pkg::KEY_W'(idx_r)};

  kdlq_ring #(
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (scan_en && jres.enq),
    .push_data (push_data),
    .pop       (pop_req),
    .pop_data  (ring_q),
    .empty     (ring_empty)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      kdlq_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_kind == kdlq_pkg::KIND_TICK) begin
            state_nxt = kdlq_pkg::S_SCAN;
            idx_nxt   = '0;
          end else if (in_kind == kdlq_pkg::KIND_READ) begin
            state_nxt = kdlq_pkg::S_POP;
            hit_nxt   = !ring_empty;
          end
        end
      end
      kdlq_pkg::S_SCAN: begin
        if (idx_r == KEY_LAST) begin
          state_nxt = kdlq_pkg::S_IDLE;
        end else begin
          idx_nxt = idx_r + KIDX_W'(1);
        end
      end
      kdlq_pkg::S_POP: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = kdlq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = kdlq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kdlq_pkg::S_IDLE;
      idx_r       <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= kdlq_pkg::DEBOUNCE_RST;
      long_r     <= kdlq_pkg::LONG_RST;
      level_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        kdlq_pkg::CFG_DEBOUNCE: debounce_r <= cfg_data;
        kdlq_pkg::CFG_LONG:     long_r     <= cfg_data;
        kdlq_pkg::CFG_LEVEL:    level_r    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // key phases
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        phase_r[k] <= kdlq_pkg::PH_IDLE;
      end
    end else if (scan_en) begin
      phase_r[idx_r] <= jres.phase_nxt;
    end else if (edge_acc && edge_ok &&
                 phase_r[edge_idx] != kdlq_pkg::PH_DEB &&
                 phase_r[edge_idx] != kdlq_pkg::PH_PRESS) begin
      phase_r[edge_idx] <= kdlq_pkg::PH_DEB;
    end
  end

  // start times and tick payload
  always_ff @(posedge clk) begin
    if (edge_acc && edge_ok &&
        phase_r[edge_idx] != kdlq_pkg::PH_DEB &&
        phase_r[edge_idx] != kdlq_pkg::PH_PRESS) begin
      start_r[edge_idx] <= in_now_ms;
    end
    if (in_acc && in_kind == kdlq_pkg::KIND_TICK) begin
      now_r    <= in_now_ms;
      levels_r <= in_key_levels;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ev_valid_r <= hit_r;
      out_type_r     <= hit_r ? ring_q[kdlq_pkg::EVT_W-1:kdlq_pkg::KEY_W] : 2'd0;
      out_key_r      <= hit_r ? ring_q[kdlq_pkg::KEY_W-1:0] : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_valid = out_ev_valid_r;
  assign out_event_type  = out_type_r;
  assign out_event_key   = out_key_r;

endmodule

`default_nettype wire
